/* hdl/ssti_pkg.sv */
// shared types, widths, register codes and helpers for the stereo sparse-tap iir filter
// no dependencies; hdl files except ssti_ram use scoped names, bench files import it
`default_nettype none

package ssti_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_W = 16;
	localparam int PAIR_W   = 2 * SAMPLE_W;
	localparam int COEF_W   = 18;
	localparam int FRAC_W   = 16;
	localparam int DLY_W    = 6;
	localparam int REG_W    = DLY_W + COEF_W;

	// tap counts and history size
	localparam int TAP_REGS      = 4;
	localparam int FORWARD_TAPS  = 4;
	localparam int FEEDBACK_TAPS = 4;
	localparam int N_LANES       = 2 * TAP_REGS;
	localparam int HIST_DEPTH    = 64;
	localparam int HIST_AW       = $clog2(HIST_DEPTH);
	localparam int CNT_W         = $clog2(HIST_DEPTH + 1);
	localparam int CMP_W         = DLY_W + 2;

	// arithmetic widths
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int SUM_W  = PROD_W + $clog2(N_LANES);

	// rounding and saturation constants
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (FRAC_W - 1));
	localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(2 ** (SAMPLE_W - 1) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI - SUM_W'(1);

	// register indexes
	localparam int REG_IDX_W = $clog2(N_LANES);
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FORWARD_TAP_A,
		REG_FORWARD_TAP_B,
		REG_FORWARD_TAP_C,
		REG_FORWARD_TAP_D,
		REG_FEEDBACK_TAP_A,
		REG_FEEDBACK_TAP_B,
		REG_FEEDBACK_TAP_C,
		REG_FEEDBACK_TAP_D
	} reg_idx_t;

	// forward tap a comes up as delay 0, gain 1.0
	localparam logic [REG_W-1:0] FORWARD_TAP_A_RESET = REG_W'(2 ** FRAC_W);

	// per-lane control carried alongside the history read
	typedef struct packed {
		logic use_cur;
		logic active;
	} lane_ctl_t;

	// history slot that lies back entries behind ptr, modulo the depth
	function automatic logic [HIST_AW-1:0] hist_addr(input logic [HIST_AW-1:0] ptr,
		input logic [DLY_W:0] back);
		logic [CMP_W-1:0] p_ext;
		logic [CMP_W-1:0] b_ext;
		logic [CMP_W-1:0] t;
		p_ext = CMP_W'(ptr);
		b_ext = CMP_W'(back);
		if (p_ext >= b_ext) begin
			t = p_ext - b_ext;
		end else begin
			t = p_ext + CMP_W'(HIST_DEPTH) - b_ext;
		end
		return t[HIST_AW-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/ssti_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module ssti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/ssti_tap_lane.sv */
// one tap lane: picks the history sample and multiplies both channels by the coefficient
// depends on ssti_pkg
`default_nettype none

module ssti_tap_lane (
	input  logic                                clk,
	input  logic                                en,
	input  ssti_pkg::lane_ctl_t                 ctl,
	input  logic [ssti_pkg::PAIR_W-1:0]         hist_data,
	input  logic [ssti_pkg::PAIR_W-1:0]         cur_data,
	input  logic signed [ssti_pkg::COEF_W-1:0]  coef,
	output logic signed [ssti_pkg::PROD_W-1:0]  prod_l_s2,
	output logic signed [ssti_pkg::PROD_W-1:0]  prod_r_s2
);

	logic [ssti_pkg::PAIR_W-1:0]         sample;
	logic signed [ssti_pkg::SAMPLE_W-1:0] smp_l;
	logic signed [ssti_pkg::SAMPLE_W-1:0] smp_r;
	logic signed [ssti_pkg::PROD_W-1:0]   mul_l;
	logic signed [ssti_pkg::PROD_W-1:0]   mul_r;

	// delay zero takes the sample that came with the item
	assign sample = ctl.use_cur ? cur_data : hist_data;
	assign smp_l  = signed'(sample[ssti_pkg::SAMPLE_W-1:0]);
	assign smp_r  = signed'(sample[ssti_pkg::PAIR_W-1:ssti_pkg::SAMPLE_W]);

	// full-width products
	assign mul_l = smp_l * coef;
	assign mul_r = smp_r * coef;

	// product register, idle lanes contribute zero
	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s2 <= ctl.active ? mul_l : '0;
			prod_r_s2 <= ctl.active ? mul_r : '0;
		end
	end

endmodule

`default_nettype wire

/* hdl/ssti_merge.sv */
// merge stage: sums the lane products per channel, rounds once and saturates
// depends on ssti_pkg
`default_nettype none

module ssti_merge (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [ssti_pkg::PROD_W-1:0] prod_l [ssti_pkg::N_LANES],
	input  logic signed [ssti_pkg::PROD_W-1:0] prod_r [ssti_pkg::N_LANES],
	output logic [ssti_pkg::PAIR_W-1:0]        result,
	output logic [ssti_pkg::PAIR_W-1:0]        out_q
);

	logic signed [ssti_pkg::SUM_W-1:0] acc_l;
	logic signed [ssti_pkg::SUM_W-1:0] acc_r;

	// add one half, floor, clamp to the sample range
	function automatic logic [ssti_pkg::SAMPLE_W-1:0] round_sat(
		input logic signed [ssti_pkg::SUM_W-1:0] s);
		logic signed [ssti_pkg::SUM_W-1:0] t;
		logic signed [ssti_pkg::SUM_W-1:0] q;
		t = s + ssti_pkg::ROUND_HALF;
		q = t >>> ssti_pkg::FRAC_W;
		if (q > ssti_pkg::SAT_HI) begin
			q = ssti_pkg::SAT_HI;
		end else if (q < ssti_pkg::SAT_LO) begin
			q = ssti_pkg::SAT_LO;
		end
		return q[ssti_pkg::SAMPLE_W-1:0];
	endfunction

	// exact sum over all lanes
	always_comb begin
		acc_l = '0;
		acc_r = '0;
		for (int i = 0; i < ssti_pkg::N_LANES; i++) begin
			acc_l = acc_l + ssti_pkg::SUM_W'(prod_l[i]);
			acc_r = acc_r + ssti_pkg::SUM_W'(prod_r[i]);
		end
	end

	// packed pair, right channel in the upper half
	assign result = {round_sat(acc_r), round_sat(acc_l)};

	// output data register
	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire

/* hdl/stereo_sparse_tap_iir_filter.sv */
// top level of the stereo sparse-tap direct-form-i iir filter
// depends on ssti_pkg, ssti_ram, ssti_tap_lane and ssti_merge
`default_nettype none

// One stereo pair in, one filtered pair out. A request is accepted on s_tvalid && s_tready
// and its result reaches m_tdata through the history read, product and output registers.
// Eight tap lanes (four feed-forward, four feedback) each read their own copy of the history
// ram and multiply in parallel; a merge stage sums, rounds and saturates. With no active
// feedback tap, or only feedback taps with delay field 2 or more, the block takes one pair
// per cycle unless the output stalls. The feedback loop through the two pipeline stages sets
// the rest: an item waits until the output it needs is written back, so a feedback tap with
// delay field 0 needs both stages empty, field 1 at most one full. Histories start cleared
// through a fill count, so no clearing pass follows reset. The user must write the tap
// registers through cfg_wen/cfg_index/cfg_data only while the block is idle; not enforced.

module stereo_sparse_tap_iir_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_wen,
	input  logic [ssti_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [ssti_pkg::REG_W-1:0]       cfg_data,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ssti_pkg::PAIR_W-1:0]      s_tdata,  // left_in [15:0], right_in [31:16]
	// output stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ssti_pkg::PAIR_W-1:0]      m_tdata   // left_out [15:0], right_out [31:16]
);

	logic [ssti_pkg::REG_W-1:0]     cfg_q [ssti_pkg::N_LANES];
	logic [ssti_pkg::HIST_AW-1:0]   ptr_q;
	logic [ssti_pkg::CNT_W-1:0]     cnt_q;
	logic                           valid_s1;
	logic                           valid_s2;
	logic                           out_valid_q;
	logic [ssti_pkg::PAIR_W-1:0]    cur_s1;
	logic [ssti_pkg::HIST_AW-1:0]   slot_s1;
	logic [ssti_pkg::HIST_AW-1:0]   slot_s2;
	logic [1:0]                     pend;
	logic                           s_acc;
	logic                           out_free;
	logic                           s1_move;
	logic                           s2_move;
	logic                           s1_free;
	logic [ssti_pkg::N_LANES-1:0]   haz_vec;
	logic [ssti_pkg::PAIR_W-1:0]    result;
	logic signed [ssti_pkg::PROD_W-1:0] prod_l [ssti_pkg::N_LANES];
	logic signed [ssti_pkg::PROD_W-1:0] prod_r [ssti_pkg::N_LANES];

	// handshake and pipeline advance
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s2_move  = valid_s2 && out_free;
	assign s1_move  = valid_s1 && (!valid_s2 || s2_move);
	assign s1_free  = !valid_s1 || s1_move;
	assign s_tready = s1_free && !(|haz_vec);
	assign m_tvalid = out_valid_q;
	assign pend     = {1'b0, valid_s1} + {1'b0, valid_s2};

	// tap registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssti_pkg::N_LANES; i++) begin
				cfg_q[i] <= (i == int'(ssti_pkg::REG_FORWARD_TAP_A))
					? ssti_pkg::FORWARD_TAP_A_RESET : '0;
			end
		end else if (cfg_wen) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// history write pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else if (s_acc) begin
			if (ptr_q == ssti_pkg::HIST_AW'(ssti_pkg::HIST_DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + ssti_pkg::HIST_AW'(1);
			end
			if (cnt_q != ssti_pkg::CNT_W'(ssti_pkg::HIST_DEPTH)) begin
				cnt_q <= cnt_q + ssti_pkg::CNT_W'(1);
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				valid_s2 <= 1'b1;
			end else if (s2_move) begin
				valid_s2 <= 1'b0;
			end
			if (s2_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage payload: current pair and its history slot
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cur_s1  <= s_tdata;
			slot_s1 <= ptr_q;
		end
		if (s1_move) begin
			slot_s2 <= slot_s1;
		end
	end

	// tap lanes with their history copies
	for (genvar k = 0; k < ssti_pkg::N_LANES; k++) begin : g_lane
		localparam bit IS_FWD = (k < ssti_pkg::TAP_REGS);
		localparam bit USED   = IS_FWD ? (k < ssti_pkg::FORWARD_TAPS)
			: ((k - ssti_pkg::TAP_REGS) < ssti_pkg::FEEDBACK_TAPS);

		logic [ssti_pkg::DLY_W-1:0]        dly;
		logic signed [ssti_pkg::COEF_W-1:0] coef;
		logic [ssti_pkg::DLY_W:0]          back;
		logic [ssti_pkg::HIST_AW-1:0]      rd_addr;
		logic [ssti_pkg::PAIR_W-1:0]       rd_data;
		ssti_pkg::lane_ctl_t               ctl_nxt;
		ssti_pkg::lane_ctl_t               ctl_s1;

		assign dly  = cfg_q[k][ssti_pkg::REG_W-1:ssti_pkg::COEF_W];
		assign coef = signed'(cfg_q[k][ssti_pkg::COEF_W-1:0]);

		// distance back in history: feedback counts from the previous output
		always_comb begin
			if (IS_FWD) begin
				back = {1'b0, dly};
			end else begin
				back = {1'b0, dly} + (ssti_pkg::DLY_W + 1)'(1);
			end
			ctl_nxt.use_cur = IS_FWD && (dly == '0);
			ctl_nxt.active  = USED
				&& (ssti_pkg::CMP_W'(dly) < ssti_pkg::CMP_W'(ssti_pkg::HIST_DEPTH))
				&& (ssti_pkg::CMP_W'(back) <= ssti_pkg::CMP_W'(cnt_q));
		end

		// feedback entry still in flight through the pipeline
		assign haz_vec[k] = !IS_FWD && ctl_nxt.active
			&& (ssti_pkg::CMP_W'(back) <= ssti_pkg::CMP_W'(pend));

		assign rd_addr = ssti_pkg::hist_addr(ptr_q, back);

		always_ff @(posedge clk) begin
			if (s_acc) begin
				ctl_s1 <= ctl_nxt;
			end
		end

		// input history copy or output history copy
		if (IS_FWD) begin : g_fwd
			ssti_ram #(
				.WIDTH (ssti_pkg::PAIR_W),
				.DEPTH (ssti_pkg::HIST_DEPTH)
			) u_ram (
				.clk   (clk),
				.we    (s_acc),
				.waddr (ptr_q),
				.wdata (s_tdata),
				.re    (s_acc),
				.raddr (rd_addr),
				.rdata (rd_data)
			);
		end else begin : g_fbk
			ssti_ram #(
				.WIDTH (ssti_pkg::PAIR_W),
				.DEPTH (ssti_pkg::HIST_DEPTH)
			) u_ram (
				.clk   (clk),
				.we    (s2_move),
				.waddr (slot_s2),
				.wdata (result),
				.re    (s_acc),
				.raddr (rd_addr),
				.rdata (rd_data)
			);
		end

		ssti_tap_lane u_lane (
			.clk       (clk),
			.en        (s1_move),
			.ctl       (ctl_s1),
			.hist_data (rd_data),
			.cur_data  (cur_s1),
			.coef      (coef),
			.prod_l_s2 (prod_l[k]),
			.prod_r_s2 (prod_r[k])
		);
	end

	// sum, round, saturate and hold the result
	ssti_merge u_merge (
		.clk    (clk),
		.en     (s2_move),
		.prod_l (prod_l),
		.prod_r (prod_r),
		.result (result),
		.out_q  (m_tdata)
	);

endmodule

`default_nettype wire

/* hdl/ssti_checker.sv */
// port-level checker for the stereo sparse-tap iir filter, bound to the top level
// depends on ssti_pkg and stereo_sparse_tap_iir_filter
`default_nettype none

module ssti_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ssti_pkg::PAIR_W-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output result changed while stalled");

	// a fresh result follows an accepted request through both pipeline stages without a stall
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
		else $error("result appeared without a matching request");

	// with the pipeline drained the input side is open
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && !$past(m_tvalid) && !$past(m_tvalid, 2)
		&& !$past(s_tvalid && s_tready) && !$past(s_tvalid && s_tready, 2)
		|-> s_tready)
		else $error("input stalled with an empty pipeline");

endmodule

bind stereo_sparse_tap_iir_filter ssti_checker u_ssti_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* bench/stereo_sparse_tap_iir_filter_checker.sv */
// checker for the stereo sparse-tap iir filter: mirrors the tap registers and both histories,
// predicts every filtered pair and compares it with the output stream
// depends on ssti_pkg for widths, tap counts and register codes
module stereo_sparse_tap_iir_filter_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [ssti_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [ssti_pkg::REG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [ssti_pkg::PAIR_W-1:0]      s_tdata,   // left_in [15:0], right_in [31:16]
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [ssti_pkg::PAIR_W-1:0]      m_tdata,   // left_out [15:0], right_out [31:16]
	output int                               fail_count,
	output int                               outstanding
);
	import ssti_pkg::*;

	localparam int     SHOW_LIMIT = 100;
	localparam longint OUT_MAX    = 2 ** (SAMPLE_W - 1) - 1;
	localparam longint OUT_MIN    = -(2 ** (SAMPLE_W - 1));

	logic [REG_W-1:0]  fwd_taps [TAP_REGS];
	logic [REG_W-1:0]  fbk_taps [TAP_REGS];
	logic [PAIR_W-1:0] in_hist  [HIST_DEPTH];
	logic [PAIR_W-1:0] out_hist [HIST_DEPTH];
	logic [PAIR_W-1:0] expected_pairs [$];
	logic [PAIR_W-1:0] want;
	int                mismatches;

	assign fail_count = mismatches;

	// one channel of one tap: sample times signed q2.16 coefficient, full width
	function automatic longint tap_term(input logic [REG_W-1:0] tap,
		input logic [PAIR_W-1:0] pair, input int ch);
		logic signed [COEF_W-1:0]   coef;
		logic signed [SAMPLE_W-1:0] sample;
		coef   = tap[COEF_W-1:0];
		sample = pair[ch*SAMPLE_W +: SAMPLE_W];
		return longint'(coef) * longint'(sample);
	endfunction

	// add one half, floor, clamp to the sample range
	function automatic logic [SAMPLE_W-1:0] round_clamp(input longint acc);
		longint q;
		q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
		if (q > OUT_MAX) begin
			q = OUT_MAX;
		end
		if (q < OUT_MIN) begin
			q = OUT_MIN;
		end
		return q[SAMPLE_W-1:0];
	endfunction

	// shift the pair into the input history, sum all taps, record the output
	function automatic logic [PAIR_W-1:0] filter_pair(input logic [PAIR_W-1:0] pair);
		logic [PAIR_W-1:0] result;
		longint            acc;
		int                dly;
		for (int d = HIST_DEPTH - 1; d > 0; d--) begin
			in_hist[d] = in_hist[d - 1];
		end
		in_hist[0] = pair;
		for (int ch = 0; ch < 2; ch++) begin
			acc = 0;
			for (int k = 0; k < FORWARD_TAPS && k < TAP_REGS; k++) begin
				dly = int'(fwd_taps[k][REG_W-1:COEF_W]);
				if (dly < HIST_DEPTH) begin
					acc += tap_term(fwd_taps[k], in_hist[dly], ch);
				end
			end
			for (int k = 0; k < FEEDBACK_TAPS && k < TAP_REGS; k++) begin
				dly = int'(fbk_taps[k][REG_W-1:COEF_W]);
				if (dly < HIST_DEPTH) begin
					acc += tap_term(fbk_taps[k], out_hist[dly], ch);
				end
			end
			result[ch*SAMPLE_W +: SAMPLE_W] = round_clamp(acc);
		end
		for (int d = HIST_DEPTH - 1; d > 0; d--) begin
			out_hist[d] = out_hist[d - 1];
		end
		out_hist[0] = result;
		return result;
	endfunction

	// watch config writes, results and requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_REGS; k++) begin
				fwd_taps[k] = '0;
				fbk_taps[k] = '0;
			end
			fwd_taps[0] = FORWARD_TAP_A_RESET;
			for (int d = 0; d < HIST_DEPTH; d++) begin
				in_hist[d]  = '0;
				out_hist[d] = '0;
			end
			expected_pairs.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// tap register writes
			if (cfg_wen) begin
				if (cfg_index <= REG_FORWARD_TAP_D) begin
					fwd_taps[int'(cfg_index) - int'(REG_FORWARD_TAP_A)] = cfg_data;
				end else begin
					fbk_taps[int'(cfg_index) - int'(REG_FEEDBACK_TAP_A)] = cfg_data;
				end
			end

			// compare a result with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_pairs.size() == 0) begin
					if (mismatches < SHOW_LIMIT) begin
						$display("%0t: result with nothing pending, expected none, got %h",
							$time, m_tdata);
					end
					mismatches++;
				end else begin
					want = expected_pairs.pop_front();
					for (int ch = 0; ch < 2; ch++) begin
						if (m_tdata[ch*SAMPLE_W +: SAMPLE_W] !== want[ch*SAMPLE_W +: SAMPLE_W]) begin
							if (mismatches < SHOW_LIMIT) begin
								$display("%0t: %s expected %0d, got %0d", $time,
									ch ? "right_out" : "left_out",
									$signed(want[ch*SAMPLE_W +: SAMPLE_W]),
									$signed(m_tdata[ch*SAMPLE_W +: SAMPLE_W]));
							end
							mismatches++;
						end
					end
				end
			end

			// predict the pair for each accepted request
			if (s_tvalid && s_tready) begin
				expected_pairs.push_back(filter_pair(s_tdata));
			end
			outstanding <= expected_pairs.size();
		end
	end

endmodule

/* bench/stereo_sparse_tap_iir_filter_tb.sv */
// testbench top for the stereo sparse-tap iir filter: clock, reset, tap programming,
// sample stream with random idling, output stall and the final verdict
// depends on ssti_pkg, the filter rtl and stereo_sparse_tap_iir_filter_checker
module stereo_sparse_tap_iir_filter_tb;
	import ssti_pkg::*;

	localparam int RUN_LIMIT       = 400000;
	localparam int IDLE_PCT        = 26;
	localparam int SETTLE_CYCLES   = 8;
	localparam int RAND_PHASES     = 10;
	localparam int ITEMS_PER_PHASE = 105;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_wen   = 1'b0;
	reg_idx_t          cfg_index = REG_FORWARD_TAP_A;
	logic [REG_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic [PAIR_W-1:0] s_tdata   = '0;
	logic              m_tready  = 1'b0;
	logic              quiet     = 1'b0;
	logic              s_tready;
	logic              m_tvalid;
	logic [PAIR_W-1:0] m_tdata;
	int                fail_count;
	int                outstanding;
	int                cycles = 0;
	logic [REG_W-1:0]  tap_setting [N_LANES];

	stereo_sparse_tap_iir_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	stereo_sparse_tap_iir_filter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("[stereo_sparse_tap_iir_filter] ERROR");
			$finish;
		end
	end

	// output stall, off during quiet stretches
	always @(posedge clk) begin
		m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	// delay field over signed q2.16 coefficient
	function automatic logic [REG_W-1:0] tap_word(input int dly, input int coef);
		return {DLY_W'(dly), COEF_W'(coef)};
	endfunction

	// mix of disabled, saturated-pattern, wide and moderate taps
	function automatic logic [REG_W-1:0] rand_tap();
		int coef;
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return tap_word($urandom_range(3), $urandom());
			3: return tap_word($urandom_range(63), $urandom());
			default: begin
				coef = $urandom_range(24576);
				if ($urandom_range(1)) begin
					coef = -coef;
				end
				return tap_word($urandom_range(7), coef);
			end
		endcase
	endfunction

	// extremes, small values and full-range samples
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return SAMPLE_W'($urandom_range(128) - 64);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// write all eight tap registers back to back
	task automatic program_taps();
		for (int i = 0; i < N_LANES; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= tap_setting[i];
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	// one stereo request, with random idle cycles ahead of it
	task automatic send_pair(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {right, left};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// stop sending and wait until every pair has come back
	task automatic finish_phase();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset taps pass the input straight through
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h8000, 16'h7FFF);
		send_pair(16'hFFFF, 16'h0001);
		send_pair(16'h1234, 16'hEDCB);
		finish_phase();

		// widest coefficients and deepest delay, heavy saturation
		tap_setting = '{tap_word(0, 'h1FFFF), tap_word(1, -131072), tap_word(63, 65536),
			tap_word(2, -65536), '0, '0, '0, '0};
		program_taps();
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h8000, 16'h7FFF);
		send_pair(16'h0000, 16'h0000);
		send_pair(16'hFFFF, 16'hFFFF);
		finish_phase();

		// gain one half: exact halves round up
		tap_setting = '{tap_word(0, 32768), '0, '0, '0, '0, '0, '0, '0};
		program_taps();
		send_pair(16'h0001, 16'hFFFF);
		send_pair(16'h0003, 16'hFFFD);
		send_pair(16'h7FFF, 16'h8000);
		finish_phase();

		// feedback on every delay class, including the longest
		tap_setting = '{tap_word(0, 65536), '0, '0, '0, tap_word(0, 32768),
			tap_word(1, -16384), tap_word(63, -1), tap_word(62, -131072)};
		program_taps();
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h8000, 16'h7FFF);
		send_pair(16'h0000, 16'h0000);
		send_pair(16'h0100, 16'hFF00);
		send_pair(16'h0000, 16'h0000);
		finish_phase();

		// random tap settings; first all ones, then all zeros, quiet stretch in the middle
		for (int p = 0; p < RAND_PHASES; p++) begin
			for (int i = 0; i < N_LANES; i++) begin
				tap_setting[i] = (p == 0) ? '1 : (p == 1) ? '0 : rand_tap();
			end
			program_taps();
			quiet <= (p == 4) || (p == 5);
			repeat (ITEMS_PER_PHASE) send_pair(rand_sample(), rand_sample());
			finish_phase();
		end

		if (fail_count == 0) begin
			$display("[stereo_sparse_tap_iir_filter] OK");
		end else begin
			$display("[stereo_sparse_tap_iir_filter] ERROR");
		end
		$finish;
	end

endmodule
